FILE: rtl/core/imx_pkg.sv
// ----------------------------------------------------------------------------
// imx_pkg
// Shared types and constants of the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package imx_pkg;

	localparam int unsigned NUM_ELEM  = 9;
	localparam int unsigned NUM_LANES = 9;
	localparam int unsigned ELEM_W    = 32;
	localparam int unsigned PROD_W    = 2 * ELEM_W;
	localparam int unsigned COF_W     = PROD_W + 1;
	localparam int unsigned DET_W     = COF_W + ELEM_W;
	localparam int unsigned DET_SHIFT = 60;
	localparam int unsigned DIV_W     = DET_W - DET_SHIFT;
	localparam int unsigned QUO_W     = 64;
	localparam int unsigned OUT_W     = 64;
	localparam int unsigned MIN_W     = 30;
	localparam int unsigned DIV_STAGES = QUO_W;

	localparam logic [MIN_W-1:0] MIN_DET_RESET = MIN_W'(1074);
	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic [DIV_W-1:0]         divisor_t;
	typedef logic [QUO_W-1:0]         quo_t;

	// divisor selection handed from the determinant stage to the lanes
	typedef struct packed {
		logic     clamped;
		divisor_t divisor;
	} det_res_t;

	// cofactor k = m[P]*m[Q] - m[S]*m[T], elements numbered row by row
	localparam int unsigned COF_P [NUM_LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int unsigned COF_Q [NUM_LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int unsigned COF_S [NUM_LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int unsigned COF_T [NUM_LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

FILE: rtl/core/imx_cof.sv
// ----------------------------------------------------------------------------
// imx_cof
// One cofactor lane: two products, then their difference.
// ----------------------------------------------------------------------------
module imx_cof (
	input  logic           clk,
	input  logic           en,
	input  imx_pkg::elem_t p,
	input  imx_pkg::elem_t q,
	input  imx_pkg::elem_t s,
	input  imx_pkg::elem_t t,
	output imx_pkg::cof_t  cof
);

	logic signed [imx_pkg::PROD_W-1:0] pq_s1;
	logic signed [imx_pkg::PROD_W-1:0] st_s1;
	imx_pkg::cof_t                     cof_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pq_s1  <= p * q;
			st_s1  <= s * t;
			cof_s2 <= imx_pkg::COF_W'(pq_s1) - imx_pkg::COF_W'(st_s1);
		end
	end

	assign cof = cof_s2;

endmodule

FILE: rtl/core/imx_det.sv
// ----------------------------------------------------------------------------
// imx_det
// Merge stage: determinant from three cofactors, floor check, divisor pick.
// ----------------------------------------------------------------------------
module imx_det (
	input  logic                           clk,
	input  logic                           en,
	input  imx_pkg::elem_t                 a,
	input  imx_pkg::elem_t                 b,
	input  imx_pkg::elem_t                 c,
	input  imx_pkg::cof_t                  cf0,
	input  imx_pkg::cof_t                  cf3,
	input  imx_pkg::cof_t                  cf6,
	input  logic [imx_pkg::MIN_W-1:0]      min_det,
	output imx_pkg::det_res_t              res
);

	localparam int unsigned LO_W = imx_pkg::ELEM_W;
	localparam int unsigned PP_W = imx_pkg::COF_W;

	imx_pkg::elem_t x_s1 [3];
	imx_pkg::elem_t x_s2 [3];
	imx_pkg::cof_t  cf   [3];

	logic signed [PP_W-1:0]           lo_s3 [3];
	logic signed [PP_W-1:0]           hi_s3 [3];
	logic signed [imx_pkg::DET_W-1:0] term_s4 [3];
	logic signed [imx_pkg::DET_W-1:0] det_s5;
	imx_pkg::det_res_t                res_s6;

	logic [imx_pkg::MIN_W-1:0] minv;
	imx_pkg::divisor_t         q30;
	logic                      below;

	assign cf[0] = cf0;
	assign cf[1] = cf3;
	assign cf[2] = cf6;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1[0] <= a;
			x_s1[1] <= b;
			x_s1[2] <= c;
			x_s2    <= x_s1;
			for (int k = 0; k < 3; k++) begin
				// split the cofactor: unsigned low word, signed high part
				lo_s3[k]   <= $signed({1'b0, cf[k][LO_W-1:0]}) * x_s2[k];
				hi_s3[k]   <= $signed(cf[k][PP_W-1:LO_W]) * x_s2[k];
				term_s4[k] <= $signed({hi_s3[k], {LO_W{1'b0}}})
				            + $signed({{LO_W{lo_s3[k][PP_W-1]}}, lo_s3[k]});
			end
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			res_s6 <= '{clamped: below, divisor: below ? imx_pkg::DIV_W'(minv) : q30};
		end
	end

	// a zero floor acts as one so the divisor never becomes zero
	assign minv  = (min_det == '0) ? imx_pkg::MIN_W'(1) : min_det;
	assign q30   = det_s5[imx_pkg::DET_W-1:imx_pkg::DET_SHIFT];
	assign below = det_s5[imx_pkg::DET_W-1] || (q30 < imx_pkg::DIV_W'(minv));
	assign res   = res_s6;

endmodule

FILE: rtl/core/imx_div.sv
// ----------------------------------------------------------------------------
// imx_div
// Pipelined restoring divider for one lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module imx_div (
	input  logic              clk,
	input  logic              en,
	input  imx_pkg::quo_t     mag,
	input  logic              neg,
	input  imx_pkg::divisor_t divisor,
	output imx_pkg::quo_t     quo,
	output logic              quo_neg
);

	localparam int unsigned N  = imx_pkg::DIV_STAGES;
	localparam int unsigned DW = imx_pkg::DIV_W;
	localparam int unsigned QW = imx_pkg::QUO_W;

	logic [DW-1:0]     rem_s [N+1];
	imx_pkg::quo_t     w_s   [N+1];
	imx_pkg::divisor_t d_s   [N+1];
	logic              n_s   [N+1];

	assign rem_s[0] = '0;
	assign w_s[0]   = mag;
	assign d_s[0]   = divisor;
	assign n_s[0]   = neg;

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW-1:0] rem_nx;

		always_comb begin
			trial  = {rem_s[j], w_s[j][QW-1]} - {1'b0, d_s[j]};
			rem_nx = trial[DW] ? {rem_s[j][DW-2:0], w_s[j][QW-1]} : trial[DW-1:0];
		end

		// dividend bits shift out at the top, quotient bits enter at the bottom
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= rem_nx;
				w_s[j+1]   <= {w_s[j][QW-2:0], ~trial[DW]};
				d_s[j+1]   <= d_s[j];
				n_s[j+1]   <= n_s[j];
			end
		end
	end

	assign quo     = w_s[N];
	assign quo_neg = n_s[N];

endmodule

FILE: rtl/core/matrix3x3_inverse_det_clamp.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_det_clamp
// Inverse of a 3x3 Q2.30 matrix by the adjugate with a determinant floor.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one matrix per transaction, nine 32-bit Q2.30 elements.
//   m_* channel: one result per matrix, nine 64-bit Q30 inverse elements
//   in tdata and the clamp flag in tuser, in input order.
//   cfg_* channel: writes min_determinant (30-bit Q30); always ready.
//   Write it only while the pipeline is empty.
// Throughput is one matrix per cycle while m_tready does not hold the
// pipeline. Nine lanes form the cofactors, a merge stage builds the
// determinant, and each lane divides in a 64-stage restoring divider
// that yields one quotient bit per stage.
// Reset clears all valid flags and loads min_determinant with 1074.
// The whole pipeline holds while a result waits on m_tready low, and
// s_tready drops for that time; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_det_clamp (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [575:0] m_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
	output logic [0:0]   m_tuser,   // det_clamped
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [29:0]  cfg_data
);

	localparam int unsigned NL    = imx_pkg::NUM_LANES;
	localparam int unsigned EW    = imx_pkg::ELEM_W;
	localparam int unsigned OW    = imx_pkg::OUT_W;
	localparam int unsigned DEPTH = 6 + imx_pkg::DIV_STAGES;

	logic                      en;
	logic [DEPTH-1:0]          vld_q;
	logic [imx_pkg::MIN_W-1:0] min_det_q;
	imx_pkg::elem_t            elem [imx_pkg::NUM_ELEM];
	imx_pkg::cof_t             cof  [NL];
	imx_pkg::det_res_t         det_res;

	imx_pkg::quo_t mag_s3 [NL];
	imx_pkg::quo_t mag_s4 [NL];
	imx_pkg::quo_t mag_s5 [NL];
	imx_pkg::quo_t mag_s6 [NL];
	logic          neg_s3 [NL];
	logic          neg_s4 [NL];
	logic          neg_s5 [NL];
	logic          neg_s6 [NL];

	logic          clamp_q [imx_pkg::DIV_STAGES];
	imx_pkg::quo_t quo     [NL];
	logic          quo_neg [NL];

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	for (genvar e = 0; e < imx_pkg::NUM_ELEM; e++) begin : g_elem
		assign elem[e] = s_tdata[e*EW +: EW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_det_q <= imx_pkg::MIN_DET_RESET;
		end else if (cfg_valid) begin
			min_det_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q    <= {vld_q[DEPTH-2:0], s_tvalid};
			m_tvalid <= vld_q[DEPTH-1];
		end
	end

	for (genvar k = 0; k < NL; k++) begin : g_lane
		imx_cof u_cof (
			.clk (clk),
			.en  (en),
			.p   (elem[imx_pkg::COF_P[k]]),
			.q   (elem[imx_pkg::COF_Q[k]]),
			.s   (elem[imx_pkg::COF_S[k]]),
			.t   (elem[imx_pkg::COF_T[k]]),
			.cof (cof[k])
		);

		// hold magnitude and sign until the divisor is ready
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s3[k] <= cof[k][imx_pkg::COF_W-1];
				mag_s3[k] <= cof[k][imx_pkg::COF_W-1]
				           ? imx_pkg::QUO_W'(-cof[k]) : imx_pkg::QUO_W'(cof[k]);
				neg_s4[k] <= neg_s3[k];
				mag_s4[k] <= mag_s3[k];
				neg_s5[k] <= neg_s4[k];
				mag_s5[k] <= mag_s4[k];
				neg_s6[k] <= neg_s5[k];
				mag_s6[k] <= mag_s5[k];
			end
		end

		imx_div u_div (
			.clk     (clk),
			.en      (en),
			.mag     (mag_s6[k]),
			.neg     (neg_s6[k]),
			.divisor (det_res.divisor),
			.quo     (quo[k]),
			.quo_neg (quo_neg[k])
		);

		// negate or saturate into the output register
		always_ff @(posedge clk) begin
			if (en) begin
				if (quo_neg[k]) begin
					m_tdata[k*OW +: OW] <= -quo[k];
				end else if (quo[k][imx_pkg::QUO_W-1]) begin
					m_tdata[k*OW +: OW] <= imx_pkg::OUT_MAX;
				end else begin
					m_tdata[k*OW +: OW] <= quo[k];
				end
			end
		end
	end

	imx_det u_det (
		.clk     (clk),
		.en      (en),
		.a       (elem[0]),
		.b       (elem[1]),
		.c       (elem[2]),
		.cf0     (cof[0]),
		.cf3     (cof[3]),
		.cf6     (cof[6]),
		.min_det (min_det_q),
		.res     (det_res)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_q[0] <= det_res.clamped;
			for (int j = 1; j < imx_pkg::DIV_STAGES; j++) begin
				clamp_q[j] <= clamp_q[j-1];
			end
			m_tuser[0] <= clamp_q[imx_pkg::DIV_STAGES-1];
		end
	end

endmodule
